// File: hdl/brd_pkg.sv
// ----------------------------------------------------------------------------
// brd_pkg
// Shared constants, types and the ring-index helper for the bounded ring deque.
// ----------------------------------------------------------------------------
package brd_pkg;

    localparam int DEPTH      = 64;
    localparam int WORD_WIDTH = 32;
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef logic [2:0]            t_op;
    typedef logic [1:0]            t_status;
    typedef logic [AW-1:0]         t_addr;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [WORD_WIDTH-1:0] t_word;

    localparam t_op OP_PUSH_FRONT = 3'd0;
    localparam t_op OP_PUSH_REAR  = 3'd1;
    localparam t_op OP_POP_FRONT  = 3'd2;
    localparam t_op OP_POP_REAR   = 3'd3;
    localparam t_op OP_PEEK_FRONT = 3'd4;
    localparam t_op OP_PEEK_REAR  = 3'd5;
    localparam t_op OP_CLEAR      = 3'd6;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    localparam t_cnt          CNT_FULL  = CNT_W'(DEPTH);
    localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(DEPTH);
    localparam t_addr         ADDR_LAST = AW'(DEPTH - 1);

    // Memory command and result info for one request
    typedef struct packed {
        logic    we;
        logic    re;
        t_addr   addr;
        t_status status;
        t_cnt    count;
    } t_ptr_cmd;

    // (head + off) mod DEPTH, off <= DEPTH
    function automatic t_addr ring_add(input t_addr head, input t_cnt off);
        logic [AW:0] sum;
        sum = {1'b0, head} + (AW + 1)'(off);
        if (sum >= DEPTH_EXT) begin
            sum = sum - DEPTH_EXT;
        end
        return sum[AW-1:0];
    endfunction

endpackage

// File: hdl/brd_if.sv
// ----------------------------------------------------------------------------
// brd_req_if / brd_rsp_if
// Valid/ready channels carrying deque requests and their results.
// ----------------------------------------------------------------------------
interface brd_req_if;
    import brd_pkg::*;

    logic               valid;
    logic               ready;
    t_op                operation;
    logic signed [31:0] push_word;

    modport source (output valid, output operation, output push_word, input ready);
    modport sink   (input valid, input operation, input push_word, output ready);
endinterface

interface brd_rsp_if;
    import brd_pkg::*;

    logic               valid;
    logic               ready;
    logic signed [31:0] read_word;
    t_status            status;
    t_cnt               entry_count;

    modport source (output valid, output read_word, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input read_word, input status, input entry_count,
                    output ready);
endinterface

// File: hdl/bounded_ring_deque.sv
// ----------------------------------------------------------------------------
// bounded_ring_deque
// Double-ended queue of signed words in a DEPTH-entry ring held in one
// single-port synchronous RAM. Every request (push front/rear, pop front/rear,
// peek front/rear, clear) returns one result: the word read, a status (ok,
// empty, full) and the entry count after the request. A request is accepted
// every cycle while the result side keeps up; its result is registered in the
// RAM read register, then in the output register. The single RAM port, used
// for the one read or write of each request, sets the rate of one request per
// cycle. Pointers update at acceptance, so a read that follows a write to the
// same entry sees the new word. The RAM needs no initialization: only entries
// written by a push are ever read.
// ----------------------------------------------------------------------------
module bounded_ring_deque (
    input  logic     i_clk,
    input  logic     i_rst_n,
    brd_req_if.sink   i_req,
    brd_rsp_if.source o_rsp
);
    import brd_pkg::*;

    t_ptr_cmd           cmd;
    logic               accept;
    logic               s1_adv;
    logic signed [63:0] push_ext;
    t_word              ram_q;
    logic [63:0]        ram_q_ext;

    // Stage 1: RAM read in flight
    logic    r_s1_vld;
    logic    r_s1_rd;
    t_status r_s1_st;
    t_cnt    r_s1_cnt;

    // Output register
    logic               r_o_vld;
    logic signed [31:0] r_o_word;
    t_status            r_o_st;
    t_cnt               r_o_cnt;

    assign s1_adv      = r_s1_vld && (!r_o_vld || o_rsp.ready);
    assign i_req.ready = !r_s1_vld || s1_adv;
    assign accept      = i_req.valid && i_req.ready;

    brd_ptr u_ptr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_operation (i_req.operation),
        .o_cmd       (cmd)
    );

    assign push_ext = 64'(i_req.push_word);

    brd_ram #(
        .DEPTH_P (DEPTH),
        .WIDTH_P (WORD_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (accept && cmd.we),
        .i_re    (accept && cmd.re),
        .i_addr  (cmd.addr),
        .i_wdata (push_ext[WORD_WIDTH-1:0]),
        .o_rdata (ram_q)
    );

    assign ram_q_ext = 64'(ram_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (accept) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_rd  <= cmd.re;
            r_s1_st  <= cmd.status;
            r_s1_cnt <= cmd.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (s1_adv) begin
            r_o_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_word <= r_s1_rd ? signed'(ram_q_ext[31:0]) : '0;
            r_o_st   <= r_s1_st;
            r_o_cnt  <= r_s1_cnt;
        end
    end

    assign o_rsp.valid       = r_o_vld;
    assign o_rsp.read_word   = r_o_word;
    assign o_rsp.status      = r_o_st;
    assign o_rsp.entry_count = r_o_cnt;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld |-> (r_o_cnt <= CNT_FULL))
        else $error("entry count above depth");

    a_full_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && r_o_st == ST_FULL) |-> (r_o_cnt == CNT_FULL && r_o_word == '0))
        else $error("full status with ring not full");

    a_empty_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && r_o_st == ST_EMPTY) |-> (r_o_cnt == '0 && r_o_word == '0))
        else $error("empty status with entries held");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !s1_adv) |=> (r_s1_vld && $stable(r_s1_cnt) && !$past(accept)))
        else $error("stalled request lost or overwritten");

    a_ram_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> !(cmd.we && cmd.re))
        else $error("read and write in one request");
`endif

endmodule

// File: hdl/brd_ram.sv
// ----------------------------------------------------------------------------
// brd_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module brd_ram #(
    parameter int DEPTH_P = 64,
    parameter int WIDTH_P = 32
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic                       i_re,
    input  logic [$clog2(DEPTH_P)-1:0] i_addr,
    input  logic [WIDTH_P-1:0]         i_wdata,
    output logic [WIDTH_P-1:0]         o_rdata
);

    logic [WIDTH_P-1:0] r_mem [DEPTH_P];
    logic [WIDTH_P-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/brd_ptr.sv
// ----------------------------------------------------------------------------
// brd_ptr
// Head index and entry count; turns one request into a RAM command.
// ----------------------------------------------------------------------------
module brd_ptr (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  brd_pkg::t_op      i_operation,
    output brd_pkg::t_ptr_cmd o_cmd
);
    import brd_pkg::*;

    t_addr    r_head, n_head;
    t_cnt     r_cnt,  n_cnt;
    t_ptr_cmd cmd;
    logic     full, empty;

    assign full  = (r_cnt == CNT_FULL);
    assign empty = (r_cnt == '0);

    always_comb begin
        n_head     = r_head;
        n_cnt      = r_cnt;
        cmd.we     = 1'b0;
        cmd.re     = 1'b0;
        cmd.addr   = r_head;
        cmd.status = ST_OK;
        case (i_operation)
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
                if (full) begin
                    cmd.status = ST_FULL;
                end else begin
                    cmd.we = 1'b1;
                    n_cnt  = r_cnt + CNT_W'(1);
                    if (i_operation == OP_PUSH_FRONT) begin
                        cmd.addr = (r_head == '0) ? ADDR_LAST : r_head - AW'(1);
                        n_head   = cmd.addr;
                    end else begin
                        cmd.addr = ring_add(r_head, r_cnt);
                    end
                end
            end
            OP_POP_FRONT, OP_POP_REAR, OP_PEEK_FRONT, OP_PEEK_REAR: begin
                if (empty) begin
                    cmd.status = ST_EMPTY;
                end else begin
                    cmd.re = 1'b1;
                    if (i_operation == OP_POP_FRONT || i_operation == OP_PEEK_FRONT) begin
                        cmd.addr = r_head;
                    end else begin
                        cmd.addr = ring_add(r_head, r_cnt - CNT_W'(1));
                    end
                    if (i_operation == OP_POP_FRONT) begin
                        n_head = ring_add(r_head, CNT_W'(1));
                        n_cnt  = r_cnt - CNT_W'(1);
                    end else if (i_operation == OP_POP_REAR) begin
                        n_cnt  = r_cnt - CNT_W'(1);
                    end
                end
            end
            OP_CLEAR: begin
                n_head = '0;
                n_cnt  = '0;
            end
            default: begin
            end
        endcase
        cmd.count = n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_cnt  <= '0;
        end else if (i_accept) begin
            r_head <= n_head;
            r_cnt  <= n_cnt;
        end
    end

    assign o_cmd = cmd;

endmodule
